// ----- src/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, codes and helpers of the periodic slot scheduler.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int SLOT_COUNT_DEF  = 8;
    localparam int PICK_PASS_LIMIT = 64;
    localparam int SLOT_NUM_W      = 6;
    localparam int TIME_W          = 64;
    localparam int WORD_W          = 32;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_PICK = 2'd1;
    localparam logic [1:0] OP_DONE = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_ZERO_PER  = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        priority_req;
        logic [TIME_W-1:0] first_time;
        logic [WORD_W-1:0] duration;
        logic [WORD_W-1:0] period;
        logic [7:0]        slot_index;
        logic [TIME_W-1:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_NUM_W-1:0] slot_number;
        logic                  is_active;
        logic [7:0]            slot_priority_out;
        logic [TIME_W-1:0]     start_time;
        logic [WORD_W-1:0]     slot_length;
        logic [WORD_W-1:0]     slot_interval;
        logic [WORD_W-1:0]     run_count;
        logic [WORD_W-1:0]     yield_count;
    } out_item_t;

    // One table entry as held in the slot memory.
    typedef struct packed {
        logic [7:0]        prio;
        logic [TIME_W-1:0] start;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] per;
        logic [WORD_W-1:0] runs;
        logic [WORD_W-1:0] yields;
    } rec_t;

    // Overlap of [a, a+da) and [b, b+db), sums kept exact.
    function automatic logic meets(logic [TIME_W-1:0] a, logic [WORD_W-1:0] da,
                                   logic [TIME_W-1:0] b, logic [WORD_W-1:0] db);
        logic [TIME_W:0] ea;
        logic [TIME_W:0] eb;
        ea = {1'b0, a} + {{(TIME_W-WORD_W+1){1'b0}}, da};
        eb = {1'b0, b} + {{(TIME_W-WORD_W+1){1'b0}}, db};
        return ({1'b0, a} < eb) && ({1'b0, b} < ea);
    endfunction

    // Move an entry by one period and count a yield.
    function automatic rec_t push_back(rec_t r);
        rec_t o;
        o        = r;
        o.start  = r.start + {{(TIME_W-WORD_W){1'b0}}, r.per};
        o.yields = r.yields + 1'b1;
        return o;
    endfunction

endpackage

// ----- src/pss_if.sv -----
// ----------------------------------------------------------------------------
// pss_in_if / pss_out_if
// Valid/ready channels for requests and results of the slot scheduler.
// ----------------------------------------------------------------------------
interface pss_in_if;
    logic               valid;
    logic               ready;
    pss_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pss_out_if;
    logic               valid;
    logic               ready;
    pss_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/periodic_slot_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_slot_scheduler
// Table of periodic slots with add, pick, done and read requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req       in         valid / ready    pss_pkg::in_item_t
//  rsp       out        valid / ready    pss_pkg::out_item_t
//
//  Add is done in the request state. Read reads the entry and evaluates it.
//  Done moves the start on by one period when it already lies past now, else
//  catches up using the bit-serial divider. Pick runs passes of two memory
//  scans, one read per entry, up to 64 passes. Each result then goes
//  through the staging register.
//  Reset clears the in-use flags at once; no clearing pass is needed.
//  A stalled result waits in the output register while the next request is
//  taken.
// ----------------------------------------------------------------------------
module periodic_slot_scheduler #(
    parameter int SLOT_COUNT = pss_pkg::SLOT_COUNT_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    pss_in_if.sink   req,
    pss_out_if.source rsp
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW = $clog2(pss_pkg::PICK_PASS_LIMIT);
    localparam int RW = $bits(pss_pkg::rec_t);

    typedef enum logic [3:0] {
        S_IDLE, S_READ_RD, S_READ_EV, S_DONE_RD, S_DONE_EV, S_DONE_DIV,
        S_FIND_RD, S_FIND_EV, S_SCAN_RD, S_SCAN_EV, S_DELIVER
    } state_t;

    state_t                     state_reg;
    logic [SLOT_COUNT-1:0]      used_reg;
    logic [AW-1:0]              ptr_reg;
    logic [AW-1:0]              best_idx_reg;
    logic                       have_best_reg;
    logic [PW-1:0]              pass_reg;
    pss_pkg::rec_t              best_reg;
    logic [pss_pkg::TIME_W-1:0] now_reg;
    pss_pkg::out_item_t         res_reg;
    pss_pkg::out_item_t         out_reg;
    logic                       out_valid_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    pss_pkg::rec_t              ram_wdata;
    logic [RW-1:0]              ram_rbits;
    pss_pkg::rec_t              rd;

    logic                       div_start;
    logic                       div_done;
    logic [pss_pkg::WORD_W-1:0] div_rem;

    logic                       has_free;
    logic [AW-1:0]              free_idx;
    logic                       idx_bad;
    logic                       accept;
    logic                       last_ptr;
    logic                       hit;
    logic                       lose;
    logic                       win;
    logic                       deliver;
    pss_pkg::rec_t              new_rec;
    pss_pkg::rec_t              caught_up;
    pss_pkg::out_item_t         first_res;

    assign rd       = pss_pkg::rec_t'(ram_rbits);
    assign accept   = req.valid && req.ready;
    assign idx_bad  = {1'b0, req.data.slot_index} >= 9'(SLOT_COUNT);
    assign last_ptr = ptr_reg == AW'(SLOT_COUNT - 1);
    assign deliver  = (state_reg == S_DELIVER) && (!out_valid_reg || rsp.ready);

    // Lowest free entry for add.
    always_comb
    begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                has_free = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    // Result known at request time: errors, add outcome, empty pick.
    always_comb
    begin
        first_res = '0;
        unique case (req.data.operation)
            pss_pkg::OP_ADD:
            begin
                if (req.data.period == '0)
                begin
                    first_res.status = pss_pkg::ST_ZERO_PER;
                end
                else if (!has_free)
                begin
                    first_res.status = pss_pkg::ST_NONE;
                end
                else
                begin
                    first_res.slot_number = pss_pkg::SLOT_NUM_W'(free_idx);
                end
            end
            pss_pkg::OP_PICK:
            begin
                if (used_reg == '0)
                begin
                    first_res.status = pss_pkg::ST_NONE;
                end
            end
            pss_pkg::OP_DONE:
            begin
                if (idx_bad)
                begin
                    first_res.status = pss_pkg::ST_BAD_INDEX;
                end
                else if (!used_reg[AW'(req.data.slot_index)])
                begin
                    first_res.status = pss_pkg::ST_NONE;
                end
            end
            pss_pkg::OP_READ:
            begin
                if (idx_bad)
                begin
                    first_res.status = pss_pkg::ST_BAD_INDEX;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Collision test of the scanned entry against the current best.
    assign hit  = used_reg[ptr_reg] && (ptr_reg != best_idx_reg) &&
                  pss_pkg::meets(best_reg.start, best_reg.len, rd.start, rd.len);
    assign lose = hit && (rd.prio < best_reg.prio);
    assign win  = hit && (rd.prio > best_reg.prio);

    always_comb
    begin
        new_rec        = '0;
        new_rec.prio   = req.data.priority_req;
        new_rec.start  = req.data.first_time;
        new_rec.len    = req.data.duration;
        new_rec.per    = req.data.period;
    end

    // Catch-up start: now - ((now - start) mod period) + period.
    always_comb
    begin
        caught_up       = best_reg;
        caught_up.start = now_reg - {{(pss_pkg::TIME_W-pss_pkg::WORD_W){1'b0}}, div_rem}
                        + {{(pss_pkg::TIME_W-pss_pkg::WORD_W){1'b0}}, best_reg.per};
        caught_up.runs  = best_reg.runs + 1'b1;
    end

    // Memory write port and divider launch.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = rd;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.data.operation == pss_pkg::OP_ADD &&
                    req.data.period != '0 && has_free)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx;
                    ram_wdata = new_rec;
                end
            end
            S_DONE_EV:
            begin
                if (rd.start > now_reg)
                begin
                    ram_we          = 1'b1;
                    ram_wdata.start = rd.start
                                    + {{(pss_pkg::TIME_W-pss_pkg::WORD_W){1'b0}}, rd.per};
                    ram_wdata.runs  = rd.runs + 1'b1;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            S_DONE_DIV:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = caught_up;
                end
            end
            S_SCAN_EV:
            begin
                if (lose)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = best_idx_reg;
                    ram_wdata = pss_pkg::push_back(best_reg);
                end
                else if (win)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = pss_pkg::push_back(rd);
                end
            end
            default:
            begin
            end
        endcase
    end

    pss_ram #(
        .WIDTH (RW),
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (RW'(ram_wdata)),
        .raddr (ptr_reg),
        .rdata (ram_rbits)
    );

    pss_divrem u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (now_reg - rd.start),
        .divisor   (rd.per),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            ptr_reg       <= '0;
            best_idx_reg  <= '0;
            have_best_reg <= 1'b0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a new result when the register frees up; drop it once its
            // transfer completes.
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_reg <= first_res;
                        now_reg <= req.data.now_time;
                        ptr_reg <= (req.data.operation == pss_pkg::OP_PICK) ?
                                   '0 : AW'(req.data.slot_index);
                        unique case (req.data.operation)
                            pss_pkg::OP_ADD:
                            begin
                                state_reg <= S_DELIVER;
                                if (req.data.period != '0 && has_free)
                                begin
                                    used_reg[free_idx] <= 1'b1;
                                end
                            end
                            pss_pkg::OP_PICK:
                            begin
                                pass_reg      <= '0;
                                have_best_reg <= 1'b0;
                                state_reg     <= (used_reg == '0) ? S_DELIVER : S_FIND_RD;
                            end
                            pss_pkg::OP_DONE:
                            begin
                                if (idx_bad || !used_reg[AW'(req.data.slot_index)])
                                begin
                                    state_reg <= S_DELIVER;
                                end
                                else
                                begin
                                    state_reg <= S_DONE_RD;
                                end
                            end
                            pss_pkg::OP_READ:
                            begin
                                state_reg <= idx_bad ? S_DELIVER : S_READ_RD;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ_RD:
                begin
                    state_reg <= S_READ_EV;
                end
                S_READ_EV:
                begin
                    // A slot never written reads as cleared.
                    res_reg.slot_number <= pss_pkg::SLOT_NUM_W'(ptr_reg);
                    if (used_reg[ptr_reg])
                    begin
                        res_reg.is_active         <= 1'b1;
                        res_reg.slot_priority_out <= rd.prio;
                        res_reg.start_time        <= rd.start;
                        res_reg.slot_length       <= rd.len;
                        res_reg.slot_interval     <= rd.per;
                        res_reg.run_count         <= rd.runs;
                        res_reg.yield_count       <= rd.yields;
                    end
                    state_reg <= S_DELIVER;
                end
                S_DONE_RD:
                begin
                    state_reg <= S_DONE_EV;
                end
                S_DONE_EV:
                begin
                    best_reg            <= rd;
                    res_reg.slot_number <= pss_pkg::SLOT_NUM_W'(ptr_reg);
                    state_reg           <= (rd.start > now_reg) ? S_DELIVER : S_DONE_DIV;
                end
                S_DONE_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DELIVER;
                    end
                end
                S_FIND_RD:
                begin
                    state_reg <= S_FIND_EV;
                end
                S_FIND_EV:
                begin
                    // Earliest start wins; strict compare keeps the lower index.
                    if (used_reg[ptr_reg] && (!have_best_reg || rd.start < best_reg.start))
                    begin
                        best_reg      <= rd;
                        best_idx_reg  <= ptr_reg;
                        have_best_reg <= 1'b1;
                    end
                    if (last_ptr)
                    begin
                        ptr_reg   <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_FIND_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_EV;
                end
                S_SCAN_EV:
                begin
                    if (lose)
                    begin
                        // Best yields: end this pass, start over or give up.
                        ptr_reg       <= '0;
                        have_best_reg <= 1'b0;
                        pass_reg      <= pass_reg + 1'b1;
                        if (pass_reg == PW'(pss_pkg::PICK_PASS_LIMIT - 1))
                        begin
                            res_reg.status <= pss_pkg::ST_NONE;
                            state_reg      <= S_DELIVER;
                        end
                        else
                        begin
                            state_reg <= S_FIND_RD;
                        end
                    end
                    else if (last_ptr)
                    begin
                        res_reg.slot_number <= pss_pkg::SLOT_NUM_W'(best_idx_reg);
                        state_reg           <= S_DELIVER;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_DELIVER:
                begin
                    // Hand the result over once the output register is free.
                    if (deliver)
                    begin
                        out_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready = state_reg == S_IDLE;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

// ----- src/pss_ram.sv -----
// ----------------------------------------------------------------------------
// pss_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/pss_divrem.sv -----
// ----------------------------------------------------------------------------
// pss_divrem
// Bit-serial restoring divider; returns the remainder of a 64 by 32 division.
// ----------------------------------------------------------------------------
module pss_divrem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pss_pkg::TIME_W-1:0]   dividend,
    input  logic [pss_pkg::WORD_W-1:0]   divisor,
    output logic                         done,
    output logic [pss_pkg::WORD_W-1:0]   remainder
);

    localparam int CW = $clog2(pss_pkg::TIME_W + 1);

    logic [CW-1:0]                cnt_reg;
    logic                         done_reg;
    logic [pss_pkg::TIME_W-1:0]   sh_reg;
    logic [pss_pkg::WORD_W-1:0]   div_reg;
    logic [pss_pkg::WORD_W-1:0]   rem_reg;
    logic [pss_pkg::WORD_W:0]     trial;
    logic [pss_pkg::WORD_W:0]     diff;

    // Shift in one dividend bit, subtract when it fits.
    assign trial = {rem_reg, sh_reg[pss_pkg::TIME_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(pss_pkg::TIME_W);
                sh_reg  <= dividend;
                div_reg <= divisor;
                rem_reg <= '0;
            end
            else if (cnt_reg != '0)
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_reg <= diff[pss_pkg::WORD_W-1:0];
                end
                else
                begin
                    rem_reg <= trial[pss_pkg::WORD_W-1:0];
                end
                sh_reg  <= {sh_reg[pss_pkg::TIME_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
